// ===== hw/rtl/dclfw_pkg.sv =====
package dclfw_pkg;

  localparam int DIGITS      = 5;
  localparam int CELL_W      = 6;
  localparam int GLYPH_W     = 5;
  localparam int ROWS        = 8;
  localparam int MODULES     = 4;
  localparam int IND_COL     = 31;
  localparam int RADIX       = 10;
  localparam int VALUE_SPAN  = 100000;
  localparam int RECIP       = 6553;
  localparam int RECIP_SHIFT = 16;
  localparam int QDEPTH      = 2;

  typedef struct packed {
    logic [16:0] value;
    logic [2:0]  indicator_row;
  } request_t;

  typedef struct packed {
    logic [11:0] word;
    logic [1:0]  module_index;
    logic        end_of_row;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [DIGITS-1:0][3:0] digits;
    logic [2:0]             indicator_row;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [GLYPH_W-1:0] glyph_row(input logic [3:0] digit,
                                                   input logic [2:0] row);
    logic [ROWS-1:0][GLYPH_W-1:0] rows;
    case (digit)
      4'd0: rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      4'd1: rows = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h06, 5'h04};
      4'd2: rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h11, 5'h0E};
      4'd3: rows = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h0C, 5'h10, 5'h11, 5'h0E};
      4'd4: rows = {5'h08, 5'h08, 5'h08, 5'h1F, 5'h09, 5'h0A, 5'h0C, 5'h08};
      4'd5: rows = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h0F, 5'h01, 5'h01, 5'h1F};
      4'd6: rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      4'd7: rows = {5'h02, 5'h02, 5'h04, 5'h04, 5'h08, 5'h08, 5'h10, 5'h1F};
      4'd8: rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      4'd9: rows = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h0E};
      default: rows = '0;
    endcase
    return rows[row];
  endfunction

endpackage

// ===== hw/rtl/dclfw_front.sv =====
module dclfw_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dclfw_pkg::request_t request,
  input  dclfw_pkg::q_status_t q_status,
  output logic                push,
  output dclfw_pkg::frame_t   push_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SPLIT = 2'd1;
  localparam logic [1:0] ST_PUSH  = 2'd2;

  localparam logic [2:0] LAST_DIGIT = 3'(dclfw_pkg::DIGITS - 1);

  logic [1:0]        state;
  logic [2:0]        cnt;
  logic [16:0]       x;
  dclfw_pkg::frame_t frame;

  logic [29:0] prod;
  logic [13:0] q0;
  logic [16:0] r0;
  logic [13:0] q;
  logic [3:0]  r;
  logic [16:0] reduced;

  always_comb begin
    reduced = (request.value >= 17'(dclfw_pkg::VALUE_SPAN)) ?
              request.value - 17'(dclfw_pkg::VALUE_SPAN) : request.value;
    prod = 30'(x) * 30'(dclfw_pkg::RECIP);
    q0   = 14'(prod >> dclfw_pkg::RECIP_SHIFT);
    r0   = x - 17'({q0, 3'b000}) - 17'({q0, 1'b0});
    if (r0 >= 17'(dclfw_pkg::RADIX)) begin
      q = q0 + 14'd1;
      r = 4'(r0 - 17'(dclfw_pkg::RADIX));
    end else begin
      q = q0;
      r = r0[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SPLIT;
            cnt   <= '0;
          end
        end
        ST_SPLIT: begin
          cnt <= cnt + 3'd1;
          if (cnt == LAST_DIGIT) state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!q_status.full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      x                   <= reduced;
      frame.indicator_row <= request.indicator_row;
    end else if (state == ST_SPLIT) begin
      x                 <= 17'(q);
      frame.digits[cnt] <= r;
    end
  end

  assign busy      = (state != ST_IDLE);
  assign push      = (state == ST_PUSH) && !q_status.full;
  assign push_data = frame;

endmodule

// ===== hw/rtl/dclfw_queue.sv =====
module dclfw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dclfw_pkg::frame_t    push_data,
  input  logic                 pop,
  output dclfw_pkg::frame_t    head,
  output dclfw_pkg::q_status_t q_status
);

  dclfw_pkg::frame_t mem [dclfw_pkg::QDEPTH];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign head           = mem[rd_ptr];
  assign q_status.full  = (count == 2'(dclfw_pkg::QDEPTH));
  assign q_status.empty = (count == 2'd0);

  assert property (@(posedge clk) disable iff (rst) push |-> !q_status.full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

// ===== hw/rtl/dclfw_back.sv =====
module dclfw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  dclfw_pkg::frame_t    head,
  input  dclfw_pkg::q_status_t q_status,
  output logic                 pop,
  output logic                 strobe,
  output dclfw_pkg::result_t   result
);

  logic              active;
  logic [4:0]        cnt;
  dclfw_pkg::frame_t cur;

  logic [2:0]  row;
  logic [1:0]  m;
  logic [31:0] line;
  logic [7:0]  pix;
  dclfw_pkg::result_t res_next;

  assign pop = !q_status.empty && (!active || cnt == 5'd31);

  always_comb begin
    row  = cnt[4:2];
    m    = ~cnt[1:0];
    line = '0;
    for (int p = 0; p < dclfw_pkg::DIGITS; p++) begin
      line[dclfw_pkg::CELL_W*p +: dclfw_pkg::GLYPH_W] =
        dclfw_pkg::glyph_row(cur.digits[dclfw_pkg::DIGITS-1-p], row);
    end
    line[dclfw_pkg::IND_COL] = (row == cur.indicator_row);
    pix = line[8*m +: 8];
    res_next.word         = {4'(4'(dclfw_pkg::ROWS) - {1'b0, row}), pix};
    res_next.module_index = m;
    res_next.end_of_row   = (m == 2'd0);
    res_next.last         = (m == 2'd0) && (row == 3'(dclfw_pkg::ROWS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    result <= res_next;
  end

  assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> result.end_of_row && result.module_index == 2'd0)
    else $error("frame end off row end");
  assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("gap inside a frame");
  assert property (@(posedge clk) disable iff (rst)
    strobe && !result.end_of_row |=>
      strobe && result.module_index == $past(result.module_index) - 2'd1)
    else $error("module order broken");

endmodule

// ===== hw/rtl/decimal_counter_led_frame_writer_unit.sv =====
// Channel  Ports                  Handshake
// request  start, busy, request   taken when start && !busy
// result   strobe, result         one word per cycle while strobe is high
//
// Each request yields 32 words, one per cycle; the back end's word counter paces
// the requests, and frames follow back to back while the queue holds the next.
// The front end splits the value into digits in its split state, then pushes the
// frame from its push state, holding there while the queue is full; a 2-entry queue
// lets it take the next request while the back end emits the current frame.
// With the back end idle, the first word reaches the result ports after the split
// and push states, the queue write, the back end's pop and its output register.
// Reset (rst, synchronous) empties the queue and idles both ends.
// The receiver cannot stall; busy only reflects the front end and a full queue.
module decimal_counter_led_frame_writer_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dclfw_pkg::request_t request,
  output logic                strobe,
  output dclfw_pkg::result_t  result
);

  dclfw_pkg::q_status_t q_status;
  dclfw_pkg::frame_t    push_data;
  dclfw_pkg::frame_t    head;
  logic                 push;
  logic                 pop;

  dclfw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  dclfw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  dclfw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .strobe   (strobe),
    .result   (result)
  );

endmodule

// ===== test/frame_word_checker.sv =====
`timescale 1ns / 1ps

module frame_word_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  dclfw_pkg::request_t request,
  input  logic                strobe,
  input  dclfw_pkg::result_t  result,
  output int                  errors,
  output int                  pending
);

  dclfw_pkg::result_t due_words[$];

  // 5x8 font, row 0 in the top byte; bit k is glyph column k
  function automatic logic [4:0] font_row(input int digit, input int row);
    logic [63:0] rows;
    case (digit)
      0: rows = 64'h0E1111111111110E;
      1: rows = 64'h040604040404040E;
      2: rows = 64'h0E1110080402011F;
      3: rows = 64'h0E11100C1010110E;
      4: rows = 64'h080C0A091F080808;
      5: rows = 64'h1F01010F1010110E;
      6: rows = 64'h0C02010F1111110E;
      7: rows = 64'h1F10080804040202;
      8: rows = 64'h0E11110E1111110E;
      default: rows = 64'h0E1111111E100806;
    endcase
    return rows[8*(7-row) +: 5];
  endfunction

  task automatic render_frame(input dclfw_pkg::request_t rq);
    int                 v;
    int                 dig[dclfw_pkg::DIGITS];
    logic [31:0]        line;
    logic [31:0]        cell_bits;
    logic [3:0]         reg_addr;
    dclfw_pkg::result_t w;
    v = int'(rq.value);
    for (int i = 0; i < dclfw_pkg::DIGITS; i++) begin
      dig[i] = v % dclfw_pkg::RADIX;
      v = v / dclfw_pkg::RADIX;
    end
    for (int r = 0; r < dclfw_pkg::ROWS; r++) begin
      line = '0;
      for (int p = 0; p < dclfw_pkg::DIGITS; p++) begin
        cell_bits = 32'(font_row(dig[dclfw_pkg::DIGITS-1-p], r));
        line = line | (cell_bits << (dclfw_pkg::CELL_W * p));
      end
      if (r == int'(rq.indicator_row)) line[dclfw_pkg::IND_COL] = 1'b1;
      reg_addr = 4'(dclfw_pkg::ROWS - r);
      for (int m = dclfw_pkg::MODULES - 1; m >= 0; m--) begin
        w.word         = {reg_addr, line[8*m +: 8]};
        w.module_index = 2'(m);
        w.end_of_row   = (m == 0);
        w.last         = (m == 0) && (r == dclfw_pkg::ROWS - 1);
        due_words      = {due_words, w};
      end
    end
  endtask

  always @(posedge clk) begin
    dclfw_pkg::result_t want;
    if (!rst) begin
      if (strobe) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, got %h", $time, result);
          errors = errors + 1;
        end else begin
          want = due_words.pop_front();
          if (result !== want) begin
            $display("%0t: word mismatch: expected word=%h mod=%0d eor=%b last=%b,",
                     $time, want.word, want.module_index, want.end_of_row, want.last);
            $display("%0t:   got word=%h mod=%0d eor=%b last=%b",
                     $time, result.word, result.module_index, result.end_of_row,
                     result.last);
            errors = errors + 1;
          end
        end
      end
      if (start && !busy) render_frame(request);
    end
    pending = due_words.size();
  end

endmodule

// ===== test/tb_decimal_counter_led_frame_writer_unit.sv =====
`timescale 1ns / 1ps

module tb_decimal_counter_led_frame_writer_unit;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  dclfw_pkg::request_t request;
  logic                strobe;
  dclfw_pkg::result_t  result;
  int                  errors;
  int                  pending;

  decimal_counter_led_frame_writer_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .strobe(strobe),
    .result(result)
  );

  frame_word_checker checker_i (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .strobe(strobe),
    .result(result),
    .errors(errors),
    .pending(pending)
  );

  always #2 clk = ~clk;

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic issue(input logic [16:0] value, input logic [2:0] ind, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    request.value = value;
    request.indicator_row = ind;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [16:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 17'($urandom_range(99999));
    else if (sel < 90) return 17'($urandom_range(131071));
    else return 17'($urandom_range(9) * 11111);
  endfunction

  initial begin
    int idle_pct[4];
    int waited;
    idle_pct = '{0, 85, 16, 0};
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // repeated digits cover every glyph; d mod 8 covers every indicator row
    for (int d = 0; d < 10; d++) issue(17'(d * 11111), d[2:0], 0);
    issue(17'd12345, 3'd7, 0);
    issue(17'd67890, 3'd0, 0);
    issue(17'd99999, 3'd7, 0);
    issue(17'd100000, 3'd3, 0);
    issue(17'd131071, 3'd5, 0);
    issue(17'd1, 3'd6, 0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      for (int i = 0; i < 39; i++) issue(pick_value(), 3'($urandom_range(7)), idle_pct[ph]);
    end

    start = 1'b0;
    waited = 0;
    while (pending != 0 && waited < 4000) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dclfw_pkg.sv
hw/rtl/dclfw_front.sv
hw/rtl/dclfw_queue.sv
hw/rtl/dclfw_back.sv
hw/rtl/decimal_counter_led_frame_writer_unit.sv
test/frame_word_checker.sv
test/tb_decimal_counter_led_frame_writer_unit.sv
